/* sv/atm_pkg.sv */
// package for the 3x3 alpha-trimmed mean filter
`timescale 1ns / 1ps
package atm_pkg;
  localparam int unsigned CH_W = 8;
  localparam int unsigned PIX_W = 32;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned TRIM_W = 4;
  localparam int unsigned IMG_W_W = 11;
  localparam int unsigned IN_TDATA_W = 32;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef enum logic {
    CFG_TRIM_COUNT  = 1'b0,
    CFG_IMAGE_WIDTH = 1'b1
  } cfg_idx_t;

  typedef logic [CH_W-1:0] chan_t;
  typedef chan_t [8:0] win_t;

  // reciprocal of the kept count: (sum * RECIP + 2^15) >> 16 style is avoided,
  // a table of quotients multiplies by 2^16/n rounded up
  function automatic logic [16:0] recip(input logic [2:0] half);
    logic [16:0] r;
    unique case (half)
      3'd0: r = 17'd7282;   // ceil(65536/9)
      3'd1: r = 17'd9363;   // ceil(65536/7)
      3'd2: r = 17'd13108;  // ceil(65536/5)
      3'd3: r = 17'd21846;  // ceil(65536/3)
      3'd4: r = 17'd65536;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction
endpackage

/* sv/atm_channel.sv */
// one channel: rank by comparison counting, trimmed sum and division, three register stages
`timescale 1ns / 1ps
module atm_channel (
  input  logic             clk,
  input  logic             en,
  input  atm_pkg::win_t    win,
  input  logic [2:0]       half,
  output atm_pkg::chan_t   mean
);
  import atm_pkg::*;

  // rank of each value: count of others that sort before it (stable order)
  logic [3:0]  rank [9];
  logic [8:0][3:0] rank_r;
  win_t        win_r;
  logic [2:0]  half_r, half2_r;
  logic [11:0] sum_nxt, sum_r;
  logic [28:0] prod;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rank[i] = '0;
      for (int j = 0; j < 9; j++) begin
        if (j != i && ((win[j] < win[i]) || (win[j] == win[i] && j < i)))
          rank[i] = rank[i] + 4'd1;
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 9; i++) begin
      if ({1'b0, rank_r[i]} >= {2'b0, half_r} && {1'b0, rank_r[i]} < 5'd9 - {2'b0, half_r})
        sum_nxt = sum_nxt + {4'b0, win_r[i]};
    end
  end

  assign prod = sum_r * recip(half2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) rank_r[i] <= rank[i];
      win_r   <= win;
      half_r  <= half;
      sum_r   <= sum_nxt;
      half2_r <= half_r;
      mean    <= prod[23:16];
    end
  end
endmodule

/* sv/alpha_trimmed_mean_3x3.sv */
// top level of the 3x3 alpha-trimmed mean filter for rgba raster streams
`timescale 1ns / 1ps
// channel | dir | tdata fields (low bit first)                          | tuser
// in_     | in  | red, green, blue, opacity                             | start_of_frame
// out_    | out | red, green, blue, opacity, centre_column, centre_row  | -
// cfg_    | in  | index 0 trim_count, index 1 image_width               | -
//
// one pixel per clock sustained while the output is not stalled; the result passes through
// the line-store read, the rank stage, the sum stage and the divide
// the pipeline advances whenever the output register is empty or being taken
// reset clears counters, window and valid flags; line stores need no clearing
// in_tready drops only while a result is waiting at the output and not taken
module alpha_trimmed_mean_3x3 #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [atm_pkg::IN_TDATA_W-1:0] in_tdata,  // red, green, blue, opacity
  input  logic                          in_tuser,  // start_of_frame
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [atm_pkg::OUT_TDATA_W-1:0] out_tdata, // red, green, blue, opacity, col, row
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [atm_pkg::IMG_W_W-1:0]   cfg_wdata
);
  import atm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

  logic [TRIM_W-1:0]  trim_r;
  logic [IMG_W_W-1:0] width_cfg_r;
  logic [CW-1:0]      col_r, width_eff;
  logic [RW-1:0]      row_r;
  logic               adv;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r      <= '0;
      width_cfg_r <= IMG_W_W'(640);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRIM_COUNT:  trim_r      <= cfg_wdata[TRIM_W-1:0];
        CFG_IMAGE_WIDTH: width_cfg_r <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    if (width_cfg_r < IMG_W_W'(3))             width_eff = CW'(3);
    else if (32'(width_cfg_r) > MAX_WIDTH)     width_eff = CW'(MAX_WIDTH);
    else                                       width_eff = CW'(width_cfg_r);
  end

  // stage 0: position update
  logic [CW-1:0] col_c;
  logic [RW-1:0] row_c;
  logic          take, keep;
  assign take = in_tvalid && in_tready;
  always_comb begin
    col_c = in_tuser ? '0 : col_r;
    row_c = in_tuser ? '0 : row_r;
    if (col_c >= width_eff) begin
      col_c = '0;
      if (32'(row_c) < MAX_HEIGHT) row_c = row_c + 1'b1;
    end
    keep = 32'(row_c) < MAX_HEIGHT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (take) begin
      col_r <= keep ? col_c + 1'b1 : col_c;
      row_r <= row_c;
    end
  end

  // stage 1: line-store read, write back at the next advance
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_q, mid_q, pix1_r;
  logic [AW-1:0]    addr1_r;
  logic [CW-1:0]    col1_r;
  logic [RW-1:0]    row1_r;
  logic [2:0]       half1_r;
  logic             v1_r;
  logic [2:0]       half_c;
  assign half_c = (trim_r > 4'd8) ? 3'd4 : trim_r[3:1];

  always_ff @(posedge clk) begin
    if (adv) begin
      up_q  <= upper_mem[col_c[AW-1:0]];
      mid_q <= middle_mem[col_c[AW-1:0]];
    end
    // a pixel is written back while the next read targets another column
    if (v1_r && adv) begin
      upper_mem[addr1_r]  <= mid_q;
      middle_mem[addr1_r] <= pix1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= take && keep;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pix1_r  <= in_tdata;
      addr1_r <= col_c[AW-1:0];
      col1_r  <= col_c;
      row1_r  <= row_c;
      half1_r <= half_c;
    end
  end

  // window columns
  logic [PIX_W-1:0] wc_r [6];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) wc_r[i] <= '0;
    end else if (adv && v1_r) begin
      wc_r[0] <= wc_r[3];
      wc_r[1] <= wc_r[4];
      wc_r[2] <= wc_r[5];
      wc_r[3] <= up_q;
      wc_r[4] <= mid_q;
      wc_r[5] <= pix1_r;
    end
  end

  logic [PIX_W-1:0] px [9];
  always_comb begin
    px[0] = wc_r[0]; px[1] = wc_r[3]; px[2] = up_q;
    px[3] = wc_r[1]; px[4] = wc_r[4]; px[5] = mid_q;
    px[6] = wc_r[2]; px[7] = wc_r[5]; px[8] = pix1_r;
  end

  logic emit1;
  assign emit1 = v1_r && row1_r >= RW'(2) && col1_r >= CW'(2);

  // stages 2..4 in the channel units
  win_t  win [4];
  chan_t mean [4];
  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 9; k++) win[c][k] = px[k][c*CH_W +: CH_W];
  end

  for (genvar c = 0; c < 4; c++) begin : g_ch
    atm_channel u_ch (
      .clk  (clk),
      .en   (adv),
      .win  (win[c]),
      .half (half1_r),
      .mean (mean[c])
    );
  end

  logic [2:0] v_pipe_r;
  logic [2:0][2*COORD_W-1:0] pos_pipe_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_pipe_r <= '0;
    else if (adv) v_pipe_r <= {v_pipe_r[1:0], emit1};
  end
  always_ff @(posedge clk) begin
    if (adv)
      pos_pipe_r <= {pos_pipe_r[1:0],
                     COORD_W'(row1_r - 1'b1), COORD_W'(col1_r - 1'b1)};
  end

  // output register: the unit outputs are held by the stall, so valid follows v_pipe
  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = v_pipe_r[2];
  assign out_tdata  = {4'b0,
                       pos_pipe_r[2][2*COORD_W-1:COORD_W], pos_pipe_r[2][COORD_W-1:0],
                       mean[3], mean[2], mean[1], mean[0]};

  // a stalled result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");
  // no input taken while stalled
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted under stall");
  // centre coordinates are interior
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[41:32] != '0 && out_tdata[51:42] != '0)
    else $error("border centre emitted");
endmodule

/* tb/testbench.sv */
// self-checking testbench for the 3x3 alpha-trimmed mean filter
`timescale 1ns / 1ps
module testbench;
  import atm_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] opacity;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [IMG_W_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [3:0] trim_reg;
  logic [10:0] width_reg;
  logic [31:0] upper_line [MAX_W];
  logic [31:0] middle_line [MAX_W];
  logic [31:0] win_cols [6];
  int unsigned col_cnt, row_cnt;

  filt_result_t expected_q [$];
  int fail_count = 0;
  int burst_left = 0;
  bit stall_en = 1'b1;

  alpha_trimmed_mean_3x3 i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // sort one channel of the window and average what survives trimming
  function automatic logic [7:0] trimmed_mean(input logic [31:0] px [9],
                                              input int sh, input int half);
    logic [7:0] v [9];
    logic [7:0] t;
    int unsigned sum;
    sum = 0;
    for (int a = 0; a < 9; a++) v[a] = px[a][sh +: 8];
    for (int a = 0; a < 9; a++)
      for (int b = 0; b < 8 - a; b++)
        if (v[b] > v[b+1]) begin
          t = v[b]; v[b] = v[b+1]; v[b+1] = t;
        end
    for (int a = half; a < 9 - half; a++) sum += v[a];
    return 8'(sum / (9 - 2 * half));
  endfunction

  // advance the predicted filter by one accepted pixel
  task automatic predict_pixel(input logic sof, input logic [31:0] pix);
    int unsigned w, half, c, r;
    logic [31:0] up, mid;
    logic [31:0] px [9];
    filt_result_t res;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    half = (trim_reg > 8) ? 4 : trim_reg / 2;
    if (sof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      if (row_cnt < MAX_H) row_cnt++;
    end
    if (row_cnt >= MAX_H) return;
    c = col_cnt;
    r = row_cnt;
    up = upper_line[c];
    mid = middle_line[c];
    if (r >= 2 && c >= 2) begin
      px[0] = win_cols[0]; px[1] = win_cols[3]; px[2] = up;
      px[3] = win_cols[1]; px[4] = win_cols[4]; px[5] = mid;
      px[6] = win_cols[2]; px[7] = win_cols[5]; px[8] = pix;
      res.red = trimmed_mean(px, 0, half);
      res.green = trimmed_mean(px, 8, half);
      res.blue = trimmed_mean(px, 16, half);
      res.opacity = trimmed_mean(px, 24, half);
      res.col = 10'(c - 1);
      res.row = 10'(r - 1);
      expected_q.push_back(res);
    end
    win_cols[0] = win_cols[3]; win_cols[1] = win_cols[4]; win_cols[2] = win_cols[5];
    win_cols[3] = up; win_cols[4] = mid; win_cols[5] = pix;
    upper_line[c] = mid;
    middle_line[c] = pix;
    col_cnt = c + 1;
  endtask

  // one pixel transaction with bursty source gaps
  task automatic send_pixel(input logic sof, input logic [31:0] pix);
    int gap;
    if (burst_left == 0) begin
      gap = stall_en ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= sof;
    in_tdata <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(sof, pix);
    @(negedge clk);
  endtask

  // wait for the pipeline to empty before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [10:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TRIM_COUNT) trim_reg = val[3:0];
    else width_reg = val;
  endtask

  function automatic logic [31:0] rand_pixel();
    return $urandom();
  endfunction

  // full frame of given size, random content
  task automatic send_frame(input int w, input int h, input int mode);
    logic [31:0] p;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        case (mode)
          0: p = rand_pixel();
          1: p = ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : 32'h0;
          default: p = {4{8'($urandom_range(0, 3) * 85)}};
        endcase
        send_pixel(r == 0 && c == 0, p);
      end
  endtask

  // checker for every result transaction
  always @(posedge clk) begin
    filt_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = filt_result_t'(out_tdata);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.red !== want.red)
          $display("%0t: red expected %h actual %h", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t: green expected %h actual %h", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
        if (got.opacity !== want.opacity)
          $display("%0t: opacity expected %h actual %h", $time, want.opacity, got.opacity);
        if (got.col !== want.col)
          $display("%0t: column expected %0d actual %0d", $time, want.col, got.col);
        if (got.row !== want.row)
          $display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
        if (got !== want) fail_count++;
      end
    end
  end

  // receiver stall pattern: periodic with random flips
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 23;
    if (!stall_en) out_tready <= 1'b1;
    else out_tready <= (stall_phase < 15) ? ($urandom_range(0, 7) != 0) : 1'b0;
  end

  // extremes of pixel fields and trim levels 0, 3, 6 and 9 on a minimal 3x3 frame
  task automatic test_directed();
    logic [31:0] pats [9];
    pats = '{32'h0, 32'hFFFF_FFFF, 32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000,
             32'hFF00_0000, 32'h8040_2010, 32'h0102_0408, 32'hFEFD_FBF7};
    write_reg(CFG_IMAGE_WIDTH, 11'd3);
    for (int t = 0; t <= 9; t += 3) begin
      write_reg(CFG_TRIM_COUNT, 11'(t));
      for (int k = 0; k < 9; k++) send_pixel(k == 0, pats[(k + t) % 9]);
      drain();
    end
  endtask

  // trim values above eight act as the median
  task automatic test_large_trim();
    write_reg(CFG_TRIM_COUNT, 11'd15);
    send_frame(4, 3, 0);
    drain();
  endtask

  // widths outside the legal range are clamped
  task automatic test_width_clamp();
    write_reg(CFG_TRIM_COUNT, 11'd2);
    write_reg(CFG_IMAGE_WIDTH, 11'd0);
    send_frame(3, 3, 0);
    drain();
    write_reg(CFG_IMAGE_WIDTH, 11'h7FF);
    send_frame(1024, 3, 1);
    drain();
  endtask

  // short frame followed by a frame start mid-line
  task automatic test_frame_restart();
    write_reg(CFG_IMAGE_WIDTH, 11'd5);
    for (int k = 0; k < 7; k++) send_pixel(k == 0, rand_pixel());
    send_frame(5, 4, 2);
    drain();
  endtask

  // random frames with random trim and small widths, all well formed
  task automatic test_random_frames();
    int w, h, sent;
    sent = 0;
    while (sent < 600) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      stall_en = ($urandom_range(0, 4) != 0);
      write_reg(CFG_TRIM_COUNT, 11'($urandom_range(0, 15)));
      write_reg(CFG_IMAGE_WIDTH, 11'(w));
      send_frame(w, h, $urandom_range(0, 2));
      sent += w * h;
      drain();
    end
    stall_en = 1'b1;
  endtask

  // too many rows: pixels past the last row are dropped
  task automatic test_row_overflow();
    write_reg(CFG_IMAGE_WIDTH, 11'd3);
    write_reg(CFG_TRIM_COUNT, 11'd8);
    stall_en = 1'b0;
    send_frame(3, MAX_H + 2, 1);
    stall_en = 1'b1;
    drain();
  endtask

  initial begin
    trim_reg = 4'd0;
    width_reg = 11'd640;
    foreach (win_cols[k]) win_cols[k] = '0;
    col_cnt = 0;
    row_cnt = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_large_trim();
    test_width_clamp();
    test_frame_restart();
    test_random_frames();
    test_row_overflow();
    drain();
    if (fail_count == 0 && expected_q.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
